// ===== rtl/ffst_pkg.sv =====
// Shared constants, types and codes for the scaled-tap FIR filter.
`timescale 1ns / 1ps

package ffst_pkg;

    // Storage sizes
    localparam int MAX_TAPS = 64;
    localparam int ADDR_W   = $clog2(MAX_TAPS);
    localparam int LEN_W    = 7;
    localparam int CNT_W    = $clog2(MAX_TAPS + 1);

    // Datapath
    localparam int DATA_W   = 32;
    localparam int PROD_W   = 2 * DATA_W;
    localparam int Q_SHIFT  = 16;
    localparam int SCALE_W  = 17;
    localparam int SPROD_W  = SCALE_W + LEN_W;
    localparam int SCNT_W   = SPROD_W - Q_SHIFT;

    localparam logic [DATA_W-1:0] UNITY_GAIN = DATA_W'(65536);

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = SCALE_W;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE   = 1'b1;

    localparam logic [LEN_W-1:0]   RST_FILTER_LENGTH = LEN_W'(64);
    localparam logic [SCALE_W-1:0] RST_SPEED_SCALE   = SCALE_W'(65536);

    // Item actions
    localparam logic ACT_FILTER = 1'b0;
    localparam logic ACT_COEF   = 1'b1;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_WRITE = 4'b0010,
        ST_RUN   = 4'b0100,
        ST_DRAIN = 4'b1000
    } state_t;

    // Control into the multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic in_vld;
    } mac_ctrl_t;

    // Status out of the multiply-accumulate unit
    typedef struct packed {
        logic prod_vld;
    } mac_stat_t;

endpackage

// ===== rtl/ffst_mac.sv =====
// Shared multiply-accumulate unit: registered product, Q16 shift, 32-bit wrapping sum.
`timescale 1ns / 1ps

module ffst_mac (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ffst_pkg::mac_ctrl_t                  ctrl,
    input  logic signed [ffst_pkg::DATA_W-1:0]   sample,
    input  logic signed [ffst_pkg::DATA_W-1:0]   coef,
    output ffst_pkg::mac_stat_t                  stat,
    output logic        [ffst_pkg::DATA_W-1:0]   acc
);

    logic signed [ffst_pkg::PROD_W-1:0] prod_reg;
    logic                               prod_vld_reg;
    logic        [ffst_pkg::DATA_W-1:0] acc_reg;
    logic        [ffst_pkg::DATA_W-1:0] acc_next;

    // Product stage
    always_ff @(posedge clk)
    begin
        prod_reg <= sample * coef;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= ctrl.in_vld;
        end
    end

    // Arithmetic shift by Q_SHIFT keeps bits [Q_SHIFT+31:Q_SHIFT]; sum wraps
    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (prod_vld_reg)
        begin
            acc_next = acc_reg
                + prod_reg[ffst_pkg::Q_SHIFT +: ffst_pkg::DATA_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign stat.prod_vld = prod_vld_reg;
    assign acc           = acc_reg;

endmodule

// ===== rtl/fir_filter_scaled_taps.sv =====
// Top level: sequencer, sample ring, coefficient store and output register.
//
//  channel | signals                                        | dir
//  --------+------------------------------------------------+-----
//  in      | in_valid, in_ready, action, sample_in,         | in
//          | coef_index, coef_value                         |
//  out     | out_valid, out_ready, sample_out               | out
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data      | in
//
// A coefficient item is written straight into the store and gives no result.
// A sample item passes through the write, run and drain states (count = terms in
// use, 1..64): one shared 32x32 multiplier and accumulator handle one term per
// cycle in the run state, and drain waits for the multiply pipeline to empty.
// in_ready is high only while the sequencer is idle; the finished result sits
// in an output register, so a stalled output only holds the next sample in drain.
// After reset the ring reads as zero and the coefficients as unity on entry 0;
// per-entry valid bits cover both stores, so there is no clearing pass.
`timescale 1ns / 1ps

module fir_filter_scaled_taps (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input items
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 action,
    input  logic signed [31:0]                   sample_in,
    input  logic        [5:0]                    coef_index,
    input  logic signed [31:0]                   coef_value,
    // result items
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [31:0]                   sample_out,
    // configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic        [ffst_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [ffst_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = ffst_pkg::ADDR_W;
    localparam int LW = ffst_pkg::LEN_W;
    localparam int CW = ffst_pkg::CNT_W;
    localparam int DW = ffst_pkg::DATA_W;

    ffst_pkg::state_t state_reg, state_next;

    // Configuration registers
    logic [LW-1:0]                filter_length_reg;
    logic [ffst_pkg::SCALE_W-1:0] speed_scale_reg;

    // Per-item registers
    logic [AW-1:0] wp_reg, wp_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [LW-1:0] len_reg, len_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] smp_reg;
    logic [AW-1:0] rd_pos_reg, rd_pos_next;
    logic [CW-1:0] k_reg, k_next;
    logic          data_vld_reg;

    // Storage
    logic [DW-1:0]       ring_mem [ffst_pkg::MAX_TAPS];
    logic [DW-1:0]       coef_mem [ffst_pkg::MAX_TAPS];
    logic [ffst_pkg::MAX_TAPS-1:0] ring_vld_reg;
    logic [ffst_pkg::MAX_TAPS-1:0] coef_vld_reg;
    logic [DW-1:0]       ring_rd_reg;
    logic [DW-1:0]       coef_rd_reg;

    // Output register
    logic          out_valid_reg;
    logic [DW-1:0] out_data_reg;

    // Decoded strobes
    logic in_acc, cfg_acc, smp_acc, coef_acc, ring_wr, rd_issue, pipe_empty, out_load;
    logic [LW-1:0]                eff_len;
    logic [LW:0]                  pos_inc, wp_inc, rd_inc;
    logic [ffst_pkg::SPROD_W-1:0] scale_prod;
    logic [ffst_pkg::SCNT_W-1:0]  scaled_cnt;
    logic [LW-1:0]                cnt_calc;

    ffst_pkg::mac_ctrl_t mac_ctrl;
    ffst_pkg::mac_stat_t mac_stat;
    logic [DW-1:0]       mac_acc;

    // Handshakes
    assign in_ready  = (state_reg == ffst_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = in_valid && in_ready;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign smp_acc   = in_acc && (action == ffst_pkg::ACT_FILTER);
    assign coef_acc  = in_acc && (action == ffst_pkg::ACT_COEF);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_length_reg <= ffst_pkg::RST_FILTER_LENGTH;
            speed_scale_reg   <= ffst_pkg::RST_SPEED_SCALE;
        end
        else if (cfg_acc)
        begin
            case (cfg_index)
                ffst_pkg::CFG_FILTER_LENGTH: filter_length_reg <= cfg_data[LW-1:0];
                ffst_pkg::CFG_SPEED_SCALE:   speed_scale_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Effective length, start position and term count for a new sample
    always_comb
    begin
        eff_len = filter_length_reg;
        if (filter_length_reg == '0)
        begin
            eff_len = LW'(1);
        end
        else if (filter_length_reg > LW'(ffst_pkg::MAX_TAPS))
        begin
            eff_len = LW'(ffst_pkg::MAX_TAPS);
        end

        pos_next = ({1'b0, wp_reg} >= eff_len) ? '0 : wp_reg;
        pos_inc  = (LW + 1)'(pos_next) + (LW + 1)'(1);
        wp_inc   = ({1'b0, eff_len} <= pos_inc) ? '0 : pos_inc;

        scale_prod = ffst_pkg::SPROD_W'(speed_scale_reg)
                   * ffst_pkg::SPROD_W'(eff_len);
        scaled_cnt = scale_prod[ffst_pkg::SPROD_W-1:ffst_pkg::Q_SHIFT];
        if (scaled_cnt > ffst_pkg::SCNT_W'(eff_len) || scaled_cnt == '0)
        begin
            cnt_calc = eff_len;
        end
        else
        begin
            cnt_calc = scaled_cnt[LW-1:0];
        end
    end

    // Ring walk during the term loop
    assign rd_issue = (state_reg == ffst_pkg::ST_RUN);
    assign rd_inc   = (LW + 1)'(rd_pos_reg) + (LW + 1)'(1);
    assign ring_wr  = (state_reg == ffst_pkg::ST_WRITE);

    always_comb
    begin
        state_next  = state_reg;
        wp_next     = wp_reg;
        len_next    = len_reg;
        cnt_next    = cnt_reg;
        rd_pos_next = rd_pos_reg;
        k_next      = k_reg;
        out_load    = 1'b0;
        pipe_empty  = !data_vld_reg && !mac_stat.prod_vld;

        case (state_reg)
            ffst_pkg::ST_IDLE:
            begin
                if (smp_acc)
                begin
                    len_next   = eff_len;
                    cnt_next   = CW'(cnt_calc);
                    wp_next    = AW'(wp_inc);
                    state_next = ffst_pkg::ST_WRITE;
                end
            end
            ffst_pkg::ST_WRITE:
            begin
                rd_pos_next = pos_reg;
                k_next      = '0;
                state_next  = ffst_pkg::ST_RUN;
            end
            ffst_pkg::ST_RUN:
            begin
                rd_pos_next = ({1'b0, len_reg} <= rd_inc) ? '0 : AW'(rd_inc);
                k_next      = k_reg + CW'(1);
                if (k_next == cnt_reg)
                begin
                    state_next = ffst_pkg::ST_DRAIN;
                end
            end
            ffst_pkg::ST_DRAIN:
            begin
                if (pipe_empty && (!out_valid_reg || out_ready))
                begin
                    out_load   = 1'b1;
                    state_next = ffst_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ffst_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ffst_pkg::ST_IDLE;
            wp_reg       <= '0;
            len_reg      <= LW'(ffst_pkg::MAX_TAPS);
            cnt_reg      <= CW'(1);
            rd_pos_reg   <= '0;
            k_reg        <= '0;
            data_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            wp_reg       <= wp_next;
            len_reg      <= len_next;
            cnt_reg      <= cnt_next;
            rd_pos_reg   <= rd_pos_next;
            k_reg        <= k_next;
            data_vld_reg <= rd_issue;
        end
    end

    // Sample and position capture
    always_ff @(posedge clk)
    begin
        if (smp_acc)
        begin
            smp_reg <= sample_in;
            pos_reg <= pos_next;
        end
    end

    // Sample ring: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (ring_wr)
        begin
            ring_mem[pos_reg] <= smp_reg;
        end
        if (rd_issue)
        begin
            ring_rd_reg <= ring_vld_reg[rd_pos_reg] ? ring_mem[rd_pos_reg] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_vld_reg <= '0;
        end
        else if (ring_wr)
        begin
            ring_vld_reg[pos_reg] <= 1'b1;
        end
    end

    // Coefficient store: written by coefficient items, read by the term loop
    always_ff @(posedge clk)
    begin
        if (coef_acc)
        begin
            coef_mem[AW'(coef_index)] <= coef_value;
        end
        if (rd_issue)
        begin
            if (coef_vld_reg[k_reg[AW-1:0]])
            begin
                coef_rd_reg <= coef_mem[k_reg[AW-1:0]];
            end
            else if (k_reg == '0)
            begin
                coef_rd_reg <= ffst_pkg::UNITY_GAIN;
            end
            else
            begin
                coef_rd_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_vld_reg <= '0;
        end
        else if (coef_acc)
        begin
            coef_vld_reg[AW'(coef_index)] <= 1'b1;
        end
    end

    // Shared multiply-accumulate
    assign mac_ctrl.clear  = ring_wr;
    assign mac_ctrl.in_vld = data_vld_reg;

    ffst_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .sample (ring_rd_reg),
        .coef   (coef_rd_reg),
        .stat   (mac_stat),
        .acc    (mac_acc)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= mac_acc;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = out_data_reg;

    // Term loop never runs past the term count or the ring length
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ffst_pkg::ST_RUN) |-> (k_reg < cnt_reg && {1'b0, rd_pos_reg} < len_reg))
        else $error("term loop out of range");

    // A result only appears once the multiply pipeline has emptied
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!data_vld_reg && !mac_stat.prod_vld))
        else $error("result loaded with terms in flight");

    // A new result is only loaded from the drain state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ffst_pkg::ST_DRAIN))
        else $error("result raised outside drain");

    // Term count never exceeds the length captured with it
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ffst_pkg::ST_RUN) |-> (cnt_reg != '0 && LW'(cnt_reg) <= len_reg))
        else $error("term count out of range");

endmodule

// ===== sim/fir_filter_scaled_taps_tb.sv =====
// Self-checking testbench for the scaled-tap FIR filter: directed cases, then random traffic.
`timescale 1ns / 1ps

module fir_filter_scaled_taps_tb;

    // Cycles to let a coefficient item or a last sample settle before a register write
    localparam int SETTLE_CYCLES = 80;
    localparam int RANDOM_PHASES = 15;
    localparam int PHASE_ITEMS   = 100;

    logic                               clk;
    logic                               rst_n;
    logic                               in_valid;
    logic                               in_ready;
    logic                               action;
    logic signed [31:0]                 sample_in;
    logic        [5:0]                  coef_index;
    logic signed [31:0]                 coef_value;
    logic                               out_valid;
    logic                               out_ready;
    logic signed [31:0]                 sample_out;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [ffst_pkg::CFG_IDX_W-1:0]     cfg_index;
    logic [ffst_pkg::CFG_DATA_W-1:0]    cfg_data;

    // Filter state as the testbench sees it
    logic [31:0]                        ring_model [ffst_pkg::MAX_TAPS];
    logic [31:0]                        coef_model [ffst_pkg::MAX_TAPS];
    int                                 wr_pos;
    logic [ffst_pkg::LEN_W-1:0]         filt_len_cfg;
    logic [ffst_pkg::SCALE_W-1:0]       speed_scale_cfg;

    // Filtered samples still owed by the block, oldest first
    logic [31:0]                        filtered_q [$];
    int                                 error_count;
    bit                                 in_gaps_on;

    // Output-side stall control
    int                                 stall_left;
    int                                 mode_left;
    bit                                 stall_mode;

    fir_filter_scaled_taps u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .sample_in  (sample_in),
        .coef_index (coef_index),
        .coef_value (coef_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // One Q16 term: full signed product, arithmetic shift by 16, low 32 bits
    function automatic logic [31:0] q16_term(logic [31:0] smp, logic [31:0] coef);
        longint ps;
        longint pc;
        longint prod;
        ps   = longint'($signed(smp));
        pc   = longint'($signed(coef));
        prod = ps * pc;
        return prod[47:16];
    endfunction

    // Store a sample, accumulate the active taps, advance the position
    function automatic logic [31:0] fir_predict(logic [31:0] smp);
        int          len;
        int          count;
        int          pos;
        int          k;
        logic [23:0] scaled;
        logic [31:0] acc;
        if (filt_len_cfg == 0)
            len = 1;
        else if (filt_len_cfg > ffst_pkg::MAX_TAPS)
            len = ffst_pkg::MAX_TAPS;
        else
            len = int'(filt_len_cfg);
        if (wr_pos >= len)
            wr_pos = 0;
        ring_model[wr_pos] = smp;
        scaled = (24'(speed_scale_cfg) * 24'(len)) >> ffst_pkg::Q_SHIFT;
        count  = (scaled > len) ? len : int'(scaled);
        if (count == 0)
            count = len;
        acc = '0;
        pos = wr_pos;
        for (k = 0; k < count; k++)
        begin
            acc += q16_term(ring_model[pos], coef_model[k]);
            pos++;
            if (pos >= len)
                pos = 0;
        end
        wr_pos++;
        if (wr_pos >= len)
            wr_pos = 0;
        return acc;
    endfunction

    // Gap length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!in_gaps_on || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Random sample: mostly full range, some small, some extremes
    function automatic logic [31:0] pick_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return $urandom;
        if (r < 9)
            return 32'($urandom_range(0, 2000)) - 32'd1000;
        case ($urandom_range(0, 3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            default: return 32'h0;
        endcase
    endfunction

    // Random coefficient: plausible Q16 gains or full range, some extremes
    function automatic logic [31:0] pick_coef();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return 32'($urandom_range(0, 131072)) - 32'd65536;
        if (r < 8)
            return $urandom;
        return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endfunction

    // Send one item; the expected result is queued when it is accepted
    task automatic send_item(logic act, logic [31:0] smp, logic [5:0] idx, logic [31:0] coef);
        int gap;
        in_valid   <= 1'b1;
        action     <= act;
        sample_in  <= (act == ffst_pkg::ACT_FILTER) ? smp : 32'($urandom);
        coef_index <= (act == ffst_pkg::ACT_COEF) ? idx : 6'($urandom);
        coef_value <= (act == ffst_pkg::ACT_COEF) ? coef : 32'($urandom);
        do
            @(posedge clk);
        while (!in_ready);
        if (act == ffst_pkg::ACT_FILTER)
            filtered_q.push_back(fir_predict(smp));
        else
            coef_model[idx] = coef;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid, wait for every owed result, then let the block go quiet
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (filtered_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write over the configuration channel
    task automatic write_register(logic [ffst_pkg::CFG_IDX_W-1:0] idx,
                                  logic [ffst_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == ffst_pkg::CFG_FILTER_LENGTH)
            filt_len_cfg = data[ffst_pkg::LEN_W-1:0];
        else
            speed_scale_cfg = data;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Reset settings: unity tap 0 passes samples through, ring starts empty
    task automatic test_default_config();
        send_item(ffst_pkg::ACT_FILTER, 32'h7FFF_FFFF, '0, '0);
        send_item(ffst_pkg::ACT_FILTER, 32'h8000_0000, '0, '0);
        send_item(ffst_pkg::ACT_FILTER, 32'hFFFF_FFFF, '0, '0);
        send_item(ffst_pkg::ACT_FILTER, 32'h0000_0000, '0, '0);
        wait_idle();
    endtask

    // Coefficient extremes at both ends of the store
    task automatic test_coef_extremes();
        send_item(ffst_pkg::ACT_COEF, '0, 6'd63, 32'h7FFF_FFFF);
        send_item(ffst_pkg::ACT_COEF, '0, 6'd1,  32'h8000_0000);
        send_item(ffst_pkg::ACT_COEF, '0, 6'd2,  32'hFFFF_FFFF);
        send_item(ffst_pkg::ACT_COEF, '0, 6'd0,  32'h8000_0000);
        send_item(ffst_pkg::ACT_FILTER, 32'h7FFF_FFFF, '0, '0);
        send_item(ffst_pkg::ACT_FILTER, 32'h8000_0000, '0, '0);
        wait_idle();
    endtask

    // Length extremes, out-of-range lengths, and a length cut below the position
    task automatic test_length_edges();
        write_register(ffst_pkg::CFG_FILTER_LENGTH, ffst_pkg::CFG_DATA_W'(64));
        repeat (3) send_item(ffst_pkg::ACT_FILTER, pick_sample(), '0, '0);
        wait_idle();
        // position now beyond the new length, so it restarts at zero
        write_register(ffst_pkg::CFG_FILTER_LENGTH, ffst_pkg::CFG_DATA_W'(2));
        repeat (2) send_item(ffst_pkg::ACT_FILTER, pick_sample(), '0, '0);
        wait_idle();
        // zero length acts as one tap
        write_register(ffst_pkg::CFG_FILTER_LENGTH, ffst_pkg::CFG_DATA_W'(0));
        send_item(ffst_pkg::ACT_FILTER, pick_sample(), '0, '0);
        wait_idle();
        write_register(ffst_pkg::CFG_FILTER_LENGTH, ffst_pkg::CFG_DATA_W'(127));
        send_item(ffst_pkg::ACT_FILTER, pick_sample(), '0, '0);
        wait_idle();
        write_register(ffst_pkg::CFG_FILTER_LENGTH, ffst_pkg::CFG_DATA_W'(65));
        send_item(ffst_pkg::ACT_FILTER, pick_sample(), '0, '0);
        wait_idle();
        write_register(ffst_pkg::CFG_FILTER_LENGTH, ffst_pkg::CFG_DATA_W'(1));
        send_item(ffst_pkg::ACT_FILTER, pick_sample(), '0, '0);
        wait_idle();
    endtask

    // Scale extremes: zero count, capped count, fractions
    task automatic test_scale_edges();
        logic [ffst_pkg::CFG_DATA_W-1:0] scales [5];
        int i;
        scales = '{17'd0, 17'd131071, 17'd1, 17'd32768, 17'd65535};
        write_register(ffst_pkg::CFG_FILTER_LENGTH, ffst_pkg::CFG_DATA_W'(8));
        for (i = 0; i < 5; i++)
        begin
            write_register(ffst_pkg::CFG_SPEED_SCALE, scales[i]);
            send_item(ffst_pkg::ACT_FILTER, pick_sample(), '0, '0);
            wait_idle();
        end
    endtask

    // Random settings per phase, random mix of samples and coefficient writes
    task automatic test_random_traffic();
        int phase;
        int n;
        int r;
        logic [ffst_pkg::LEN_W-1:0]   len;
        logic [ffst_pkg::SCALE_W-1:0] scale;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            r = $urandom_range(0, 9);
            if (r < 3)
                len = ffst_pkg::LEN_W'($urandom_range(1, 8));
            else if (r < 7)
                len = ffst_pkg::LEN_W'($urandom_range(9, 63));
            else if (r < 8)
                len = ffst_pkg::LEN_W'(ffst_pkg::MAX_TAPS);
            else if (r < 9)
                len = '0;
            else
                len = ffst_pkg::LEN_W'($urandom_range(65, 127));
            r = $urandom_range(0, 9);
            if (r < 3)
                scale = ffst_pkg::SCALE_W'(65536);
            else if (r < 5)
                scale = '0;
            else if (r < 7)
                scale = ffst_pkg::SCALE_W'($urandom_range(0, 65535));
            else if (r < 8)
                scale = ffst_pkg::SCALE_W'($urandom_range(65537, 131071));
            else
                scale = ffst_pkg::SCALE_W'($urandom_range(1, 4) * 16384);
            // upper data bits above the length field are ignored by the block
            if ($urandom_range(0, 1) != 0)
            begin
                write_register(ffst_pkg::CFG_FILTER_LENGTH,
                               {(ffst_pkg::CFG_DATA_W - ffst_pkg::LEN_W)'($urandom), len});
                write_register(ffst_pkg::CFG_SPEED_SCALE, scale);
            end
            else
            begin
                write_register(ffst_pkg::CFG_SPEED_SCALE, scale);
                write_register(ffst_pkg::CFG_FILTER_LENGTH,
                               {(ffst_pkg::CFG_DATA_W - ffst_pkg::LEN_W)'($urandom), len});
            end
            in_gaps_on = ($urandom_range(0, 3) != 0);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 99) < 85)
                    send_item(ffst_pkg::ACT_FILTER, pick_sample(), '0, '0);
                else
                    send_item(ffst_pkg::ACT_COEF, '0, 6'($urandom), pick_coef());
            end
            wait_idle();
        end
    endtask

    // Output ready: stretches of always-ready and stretches with stalls
    initial
    begin
        out_ready  <= 1'b0;
        stall_left = 0;
        mode_left  = 0;
        stall_mode = 1'b0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                mode_left  = $urandom_range(50, 400);
                stall_mode = ($urandom_range(0, 2) != 0);
            end
            mode_left--;
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (stall_mode && $urandom_range(0, 5) == 0)
            begin
                stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                         : $urandom_range(7, 39);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Result check against the oldest owed sample
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (filtered_q.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, got %h", $time, sample_out);
                error_count++;
            end
            else
            begin
                if (sample_out !== filtered_q[0])
                begin
                    $display("%0t: sample_out mismatch: expected %h, got %h",
                             $time, filtered_q[0], sample_out);
                    error_count++;
                end
                void'(filtered_q.pop_front());
            end
        end
    end

    // Main sequence
    initial
    begin
        int i;
        for (i = 0; i < ffst_pkg::MAX_TAPS; i++)
        begin
            ring_model[i] = '0;
            coef_model[i] = '0;
        end
        coef_model[0]   = ffst_pkg::UNITY_GAIN;
        wr_pos          = 0;
        filt_len_cfg    = ffst_pkg::RST_FILTER_LENGTH;
        speed_scale_cfg = ffst_pkg::RST_SPEED_SCALE;
        error_count     = 0;
        in_gaps_on      = 1'b1;

        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        action     <= ffst_pkg::ACT_FILTER;
        sample_in  <= '0;
        coef_index <= '0;
        coef_value <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= ffst_pkg::CFG_FILTER_LENGTH;
        cfg_data   <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_config();
        test_coef_extremes();
        test_length_edges();
        test_scale_edges();
        test_random_traffic();

        wait_idle();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ffst_pkg.sv
rtl/ffst_mac.sv
rtl/fir_filter_scaled_taps.sv
sim/fir_filter_scaled_taps_tb.sv
